/* rtl/core/rtcrf_pkg.sv */
// Package for the clock chip register file: access codes, register
// addresses, store geometry and the BCD digit split.
// No dependencies.
package rtcrf_pkg;

  localparam int NibblesPerBlock = 13;
  localparam int StoreDepth      = 39;
  localparam int StoreIdxW       = $clog2(StoreDepth);

  typedef logic [1:0]           action_t;
  typedef logic [3:0]           nibble_t;
  typedef logic [StoreIdxW-1:0] store_idx_t;

  localparam action_t ACT_ADDR  = 2'd0;
  localparam action_t ACT_WRITE = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  localparam nibble_t ADDR_LAST_DATA = 4'd12;
  localparam nibble_t ADDR_MODE      = 4'hd;
  localparam nibble_t ADDR_TEST      = 4'he;
  localparam nibble_t ADDR_RESET     = 4'hf;

  localparam int AlarmClrLo = 2;
  localparam int AlarmClrHi = 8;

  localparam logic [7:0] HIGH_ONES = 8'hf0;

  // Source of the nibble returned by a read
  typedef logic [1:0] rd_src_t;
  localparam rd_src_t SRC_MODE  = 2'd0;
  localparam rd_src_t SRC_ONES  = 2'd1;
  localparam rd_src_t SRC_TIME  = 2'd2;
  localparam rd_src_t SRC_STORE = 2'd3;

  // Tens or units digit of a 7-bit value; quotient by reciprocal 205/2048
  function automatic nibble_t bcd_digit(input logic [6:0] v, input logic tens);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    logic [6:0]  rem;
    prod = {8'd0, v} * 15'd205;
    q    = prod[14:11];
    q10  = {q, 3'd0} - 7'd0 + {2'd0, q, 1'b0};
    rem  = v - q10;
    bcd_digit = tens ? q : rem[3:0];
  endfunction

endpackage

/* rtl/core/rtc_register_file.sv */
// Clock chip register file: address latch, mode and test registers,
// three 13-nibble blocks and live BCD time reads.
// Depends on rtcrf_pkg.
//
// Use: each input word is one bus access. in_tuser carries the access kind
// (address write, data write, data read); in_tdata carries the bus byte and
// the current time fields. Address and data writes update state in the
// cycle the word is accepted and produce no output word. A data read gives
// one output word on out_tdata with the upper nibble set.
// A read passes through the registered store read and then the output
// register before it appears on out_tvalid.
// Throughput: one access per cycle while in_tready is high; the single store port takes one read or
// one write each cycle.
// Stall: with out_tready low, one read waits in the output register and one
// more in the read stage; in_tready then drops until the output drains.
// Reset: address latch, mode and test registers clear, all stored nibbles
// read as zero through per-entry valid bits; no clearing pass is needed.
module rtc_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] bus_value, [13:8] now_seconds, [19:14] now_minutes,
  // [24:20] now_hours, [27:25] now_weekday, [32:28] now_day,
  // [36:33] now_month, [43:37] now_year, [47:44] zero
  input  logic [47:0] in_tdata,
  // [1:0] action
  input  rtcrf_pkg::action_t in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_byte
  output logic [7:0]  out_tdata
);
  import rtcrf_pkg::*;

  logic [7:0] bus_value;
  logic [5:0] now_seconds;
  logic [5:0] now_minutes;
  logic [4:0] now_hours;
  logic [2:0] now_weekday;
  logic [4:0] now_day;
  logic [3:0] now_month;
  logic [6:0] now_year;

  assign bus_value   = in_tdata[7:0];
  assign now_seconds = in_tdata[13:8];
  assign now_minutes = in_tdata[19:14];
  assign now_hours   = in_tdata[24:20];
  assign now_weekday = in_tdata[27:25];
  assign now_day     = in_tdata[32:28];
  assign now_month   = in_tdata[36:33];
  assign now_year    = in_tdata[43:37];

  nibble_t addr_r, addr_nxt;
  nibble_t mode_r, mode_nxt;
  nibble_t test_r, test_nxt;

  logic [StoreDepth-1:0] vld_r, vld_nxt;
  nibble_t               mem [StoreDepth];
  nibble_t               mem_rd_r;

  logic    s1_valid_r, s1_valid_nxt;
  rd_src_t s1_src_r;
  nibble_t s1_nib_r;
  logic    s1_hit_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;

  logic       out_free;
  logic       in_accept;
  logic       s1_advance;
  logic [1:0] block;
  logic       is_data_addr;
  logic       do_store_wr;
  logic       do_clear;
  logic       do_read;
  store_idx_t idx;
  store_idx_t base;
  rd_src_t    src;
  logic [6:0] time_val;
  logic       time_tens;
  nibble_t    time_nib;
  nibble_t    s1_nib_sel;
  nibble_t    s1_value;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || out_free;
  assign in_accept  = in_tvalid && in_tready;
  assign s1_advance = s1_valid_r && out_free;

  assign block        = mode_r[1:0];
  assign is_data_addr = addr_r <= ADDR_LAST_DATA;
  assign do_store_wr  = in_accept && (in_tuser == ACT_WRITE) && is_data_addr &&
                        (block != 2'd0);
  assign do_clear     = in_accept && (in_tuser == ACT_WRITE) &&
                        (addr_r == ADDR_RESET) && bus_value[0];
  assign do_read      = in_accept && (in_tuser == ACT_READ);

  always_comb begin
    case (block)
      2'd2:    base = StoreIdxW'(NibblesPerBlock);
      2'd3:    base = StoreIdxW'(2 * NibblesPerBlock);
      default: base = '0;
    endcase
    idx = base + StoreIdxW'(addr_r);
  end

  always_comb begin
    time_tens = 1'b0;
    time_val  = '0;
    case (addr_r)
      4'd0, 4'd1: begin
        time_val  = {1'b0, now_seconds};
        time_tens = addr_r[0];
      end
      4'd2, 4'd3: begin
        time_val  = {1'b0, now_minutes};
        time_tens = addr_r[0];
      end
      4'd4, 4'd5: begin
        time_val  = {2'd0, now_hours};
        time_tens = addr_r[0];
      end
      4'd7, 4'd8: begin
        time_val  = {2'd0, now_day};
        time_tens = !addr_r[0];
      end
      4'd9, 4'd10: begin
        time_val  = {3'd0, now_month};
        time_tens = !addr_r[0];
      end
      4'd11, 4'd12: begin
        time_val  = now_year;
        time_tens = !addr_r[0];
      end
      default: begin
        time_val  = '0;
        time_tens = 1'b0;
      end
    endcase
    if (addr_r == 4'd6) begin
      time_nib = {1'b0, now_weekday};
    end else begin
      time_nib = bcd_digit(time_val, time_tens);
    end
  end

  always_comb begin
    if (addr_r == ADDR_MODE) begin
      src = SRC_MODE;
    end else if (addr_r == ADDR_TEST || addr_r == ADDR_RESET) begin
      src = SRC_ONES;
    end else if (block == 2'd0) begin
      src = SRC_TIME;
    end else begin
      src = SRC_STORE;
    end
    s1_nib_sel = (src == SRC_MODE) ? mode_r : time_nib;
  end

  always_comb begin
    addr_nxt = addr_r;
    mode_nxt = mode_r;
    test_nxt = test_r;
    vld_nxt  = vld_r;
    if (in_accept && in_tuser == ACT_ADDR) begin
      addr_nxt = bus_value[3:0];
    end
    if (in_accept && in_tuser == ACT_WRITE && addr_r == ADDR_MODE) begin
      mode_nxt = bus_value[3:0];
    end
    if (in_accept && in_tuser == ACT_WRITE && addr_r == ADDR_TEST) begin
      test_nxt = bus_value[3:0];
    end
    if (do_store_wr) begin
      vld_nxt[idx] = 1'b1;
    end
    if (do_clear) begin
      vld_nxt[AlarmClrHi:AlarmClrLo] = '0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (do_read) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    case (s1_src_r)
      SRC_MODE, SRC_TIME: s1_value = s1_nib_r;
      SRC_ONES:           s1_value = 4'hf;
      SRC_STORE:          s1_value = s1_hit_r ? mem_rd_r : 4'h0;
      default:            s1_value = 4'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      mode_r      <= '0;
      test_r      <= '0;
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      addr_r      <= addr_nxt;
      mode_r      <= mode_nxt;
      test_r      <= test_nxt;
      vld_r       <= vld_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store_wr) begin
      mem[idx] <= bus_value[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      mem_rd_r <= mem[idx];
      s1_hit_r <= vld_r[idx];
      s1_src_r <= src;
      s1_nib_r <= s1_nib_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_byte_r <= HIGH_ONES | {4'h0, s1_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_read && s1_valid_r && !out_free))
    else $error("read accepted into a full read stage");

  a_clear_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> vld_r[AlarmClrHi:AlarmClrLo] == '0)
    else $error("alarm nibbles not cleared");

  a_store_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_store_wr |=> vld_r[$past(idx)])
    else $error("stored nibble not marked valid");

  a_high_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_byte_r[7:4] == 4'hf)
    else $error("read byte upper nibble not set");

  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && in_tuser == ACT_WRITE) |=> $stable(mode_r))
    else $error("mode register changed without a data write");
`endif

endmodule
